// File: sv/range_coder_byte_output_macros.svh
// ----------------------------------------------------------------------------
// Range coder byte output: assertion macros
// Clocked, reset-qualified assertion forms shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef RANGE_CODER_BYTE_OUTPUT_MACROS_SVH
`define RANGE_CODER_BYTE_OUTPUT_MACROS_SVH

// Plain property on clk, disabled in reset.
`define RCBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication on clk, disabled in reset.
`define RCBO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/rcbo_pkg.sv
// ----------------------------------------------------------------------------
// rcbo_pkg
// Types, codes and defaults shared by the range coder byte output block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcbo_pkg;

  localparam int PROB_BITS_DEF    = 15;
  localparam int PENDING_BITS_DEF = 32;
  localparam int FIELD_W          = 17;

  localparam logic [1:0] CMD_PUT = 2'd0;
  localparam logic [1:0] CMD_SYM = 2'd1;
  localparam logic [1:0] CMD_FIN = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SYM_ENTER,
    OP_PUT_EXIT,
    OP_CARRY,
    OP_CARRY_LAR,
    OP_CARRY_PUT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_SUM,
    OP_PUT_LO,
    OP_SET_R,
    OP_PUT_DONE,
    OP_SYM_ADD,
    OP_SHF_LOW,
    OP_PUSH,
    OP_SYM_DONE,
    OP_FIN_T,
    OP_FIN_HI,
    OP_FIN_D,
    OP_FIN_EMIT,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    M_QC,
    M_QR,
    M_RC,
    M_RR
  } msel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_PCHK, S_PEXIT, S_DINIT, S_DSTEP,
    S_MLO, S_MHI, S_MSUM,
    S_PLO, S_PQ, S_PCARRY, S_PPUSH, S_PDONE,
    S_SENTER, S_SADD, S_SR, S_SCHK, S_SSHF, S_SPUSH, S_SDONE,
    S_FENTER, S_FCHK, S_FT, S_FHI, S_FD, S_FSEL, S_FLOOP, S_FEMIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       mode;
    logic       div_last;
    logic       put_small;
    logic       sym_small;
    logic       k_is2;
    logic       hi_gt;
    logic       fin_more;
    logic       slot_free;
    logic       out_free;
    logic       stg_valid;
  } ctl_stat_t;

endpackage

// File: sv/rcbo_datapath.sv
// ----------------------------------------------------------------------------
// rcbo_datapath
// Coder state, divider and shared split multiplier, byte/carry resolution and
// the staging and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "range_coder_byte_output_macros.svh"

module rcbo_datapath #(
  parameter int PROB_BITS    = 15,
  parameter int PENDING_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rcbo_pkg::ctl_cmd_t         cmd,
  output rcbo_pkg::ctl_stat_t        stat,
  input  logic [1:0]                 command,
  input  logic [rcbo_pkg::FIELD_W-1:0] scale,
  input  logic [rcbo_pkg::FIELD_W-1:0] cum_low,
  input  logic [rcbo_pkg::FIELD_W-1:0] cum_range,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic [31:0]                fill_count,
  output logic [7:0]                 fill_value,
  output logic                       last
);
  import rcbo_pkg::*;

  localparam logic [63:0] PUT_MIN = 64'd1 << 32;
  localparam logic [63:0] SYM_MIN = 64'd1 << (33 - PROB_BITS);
  localparam logic [63:0] RANGE_INIT = 64'd1 << 63;
  localparam logic [PENDING_BITS-1:0] PMAX = {PENDING_BITS{1'b1}};

  // coder state
  logic [63:0] low, range, lar;
  logic        mode;
  logic [7:0]  cache;
  logic        cvalid;
  logic [PENDING_BITS-1:0] pend;

  // latched item
  logic [1:0]         cmd_r;
  logic [FIELD_W-1:0] scale_r, clo_r, cra_r;

  // work registers
  logic [63:0] dq, prod, lo_tmp, rng_tmp, shf, diff;
  logic [16:0] rem, dvs;
  logic [5:0]  dcnt;
  logic [2:0]  k;
  logic [48:0] plo;
  logic [31:0] phi;

  // staging and output
  logic        stg_v;
  logic [7:0]  stg_lead, stg_fill;
  logic [PENDING_BITS-1:0] stg_cnt;

  logic [63:0]        ma;
  logic [FIELD_W-1:0] mb;
  logic [17:0]        trial;
  logic               trial_ge;

  logic [7:0]  c_next, em_lead, em_fill, pb;
  logic        v_next, em_v, do_carry;
  logic [PENDING_BITS-1:0] p_next, em_cnt;

  always_comb begin
    case (cmd.msel)
      M_QC:    begin ma = dq;    mb = clo_r; end
      M_QR:    begin ma = dq;    mb = cra_r; end
      M_RC:    begin ma = range; mb = clo_r; end
      default: begin ma = range; mb = cra_r; end
    endcase
  end

  assign trial    = {rem, dq[63]};
  assign trial_ge = trial >= {1'b0, dvs};
  assign pb       = shf[63:56];

  // cache byte / pending run resolution
  always_comb begin
    c_next   = cache;
    v_next   = cvalid;
    p_next   = pend;
    em_v     = 1'b0;
    em_lead  = cache;
    em_cnt   = pend;
    em_fill  = 8'hFF;
    do_carry = (cmd.op == OP_CARRY) ||
               (cmd.op == OP_CARRY_LAR && low < lar) ||
               (cmd.op == OP_CARRY_PUT && lo_tmp < low);
    if (do_carry && cvalid) begin
      c_next = cache + 8'd1;
      if (pend != '0) begin
        em_v    = 1'b1;
        em_lead = cache + 8'd1;
        em_cnt  = pend - 1'b1;
        em_fill = 8'h00;
        c_next  = 8'h00;
        p_next  = '0;
      end
    end
    if (cmd.op == OP_PUSH) begin
      if (!cvalid) begin
        c_next = pb;
        v_next = 1'b1;
        p_next = '0;
      end else if (pb == 8'hFF && pend != PMAX) begin
        p_next = pend + 1'b1;
      end else begin
        em_v   = 1'b1;
        c_next = pb;
        p_next = '0;
      end
    end
    // final flush: emit what the cache holds, then start over empty
    if (cmd.op == OP_FIN_EMIT) begin
      em_v   = cvalid;
      c_next = '0;
      v_next = 1'b0;
      p_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low    <= '0;
      range  <= RANGE_INIT;
      mode   <= 1'b0;
      lar    <= '0;
      cache  <= '0;
      cvalid <= 1'b0;
      pend   <= '0;
    end else begin
      cache  <= c_next;
      cvalid <= v_next;
      pend   <= p_next;
      unique case (cmd.op)
        OP_SYM_ENTER: begin
          if (!mode) begin
            range <= range >> (PROB_BITS - 1);
            lar   <= low;
            mode  <= 1'b1;
          end
        end
        OP_PUT_EXIT: begin
          range <= range << (PROB_BITS - 1);
          mode  <= 1'b0;
        end
        OP_PUT_DONE: begin
          if (rng_tmp <= PUT_MIN) begin
            low   <= lo_tmp << 24;
            range <= rng_tmp << 24;
          end else begin
            low   <= lo_tmp;
            range <= rng_tmp;
          end
        end
        OP_SYM_ADD: low <= low + prod;
        OP_SYM_DONE: begin
          if ((rng_tmp >> PROB_BITS) <= SYM_MIN) begin
            low   <= low << 24;
            lar   <= low << 24;
            range <= rng_tmp << (24 - PROB_BITS);
          end else begin
            range <= rng_tmp >> PROB_BITS;
          end
        end
        OP_FIN_EMIT: begin
          low    <= '0;
          range  <= RANGE_INIT;
          mode   <= 1'b0;
          lar    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r   <= command;
        scale_r <= scale;
        clo_r   <= cum_low;
        cra_r   <= cum_range;
      end
      OP_DIV_INIT: begin
        dq   <= range;
        rem  <= '0;
        dcnt <= '0;
        dvs  <= (scale_r == '0) ? 17'd1 : scale_r;
      end
      OP_DIV_STEP: begin
        rem  <= trial_ge ? 17'(trial - {1'b0, dvs}) : trial[16:0];
        dq   <= {dq[62:0], trial_ge};
        dcnt <= dcnt + 6'd1;
      end
      OP_MUL_LO:    plo <= ma[31:0] * mb;
      OP_MUL_HI:    phi <= 32'(ma[63:32] * mb);
      OP_MUL_SUM:   prod <= {15'd0, plo} + {phi, 32'd0};
      OP_PUT_LO:    lo_tmp <= low + {prod[62:0], 1'b0};
      OP_SET_R:     rng_tmp <= prod;
      OP_CARRY_PUT: begin
        shf <= lo_tmp;
        k   <= '0;
      end
      OP_SHF_LOW: begin
        shf <= low;
        k   <= '0;
      end
      OP_PUSH: begin
        shf  <= shf << 8;
        diff <= diff << 8;
        k    <= k + 3'd1;
      end
      OP_FIN_T:  shf <= (range << PROB_BITS) - 64'd1;
      OP_FIN_HI: shf <= low + shf;
      OP_FIN_D: begin
        diff <= low ^ shf;
        k    <= '0;
      end
      default: ;
    endcase
  end

  // one staged result so the final one of an item can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (em_v) begin
        if (stg_v) begin
          out_valid <= 1'b1;
          last      <= 1'b0;
          out_byte  <= stg_lead;
          fill_count <= 32'(stg_cnt);
          fill_value <= stg_fill;
        end else if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        stg_v    <= 1'b1;
        stg_lead <= em_lead;
        stg_cnt  <= em_cnt;
        stg_fill <= em_fill;
      end else if (cmd.op == OP_FLUSH) begin
        out_valid  <= 1'b1;
        last       <= 1'b1;
        out_byte   <= stg_lead;
        fill_count <= 32'(stg_cnt);
        fill_value <= stg_fill;
        stg_v      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.mode      = mode;
    stat.div_last  = (dcnt == 6'd63);
    stat.put_small = (rng_tmp <= PUT_MIN);
    stat.sym_small = ((rng_tmp >> PROB_BITS) <= SYM_MIN);
    stat.k_is2     = (k == 3'd2);
    stat.hi_gt     = (shf > low);
    stat.fin_more  = (diff[63:56] == 8'd0) && (k != 3'd7);
    stat.out_free  = !out_valid || out_ready;
    stat.slot_free = !stg_v || !out_valid || out_ready;
    stat.stg_valid = stg_v;
  end

  `RCBO_ASSERT_IMP(a_emit_room, em_v && stg_v, !out_valid || out_ready,
                   "result emitted with staging and output both full")
  `RCBO_ASSERT_IMP(a_flush_has_data, cmd.op == OP_FLUSH, stg_v && (!out_valid || out_ready),
                   "flush issued without a staged result or output room")

endmodule

// File: sv/rcbo_ctrl.sv
// ----------------------------------------------------------------------------
// rcbo_ctrl
// Sequencer: steps each item through the carry, divide, multiply, byte push and flush steps its command needs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "range_coder_byte_output_macros.svh"

module rcbo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcbo_pkg::ctl_stat_t stat,
  output rcbo_pkg::ctl_cmd_t  cmd
);
  import rcbo_pkg::*;

  state_t state, state_next, ret, ret_next;
  msel_t  msel, msel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      msel  <= M_QC;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      msel  <= msel_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    msel_next  = msel;
    cmd.op     = OP_NONE;
    cmd.msel   = msel;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.cmd)
          CMD_PUT: state_next = stat.mode ? S_PCHK : S_DINIT;
          CMD_SYM: state_next = S_SENTER;
          CMD_FIN: state_next = S_FENTER;
          default: state_next = S_IDLE;
        endcase
      end
      S_PCHK: if (stat.slot_free) begin
        cmd.op     = OP_CARRY_LAR;
        state_next = S_PEXIT;
      end
      S_PEXIT: begin
        cmd.op     = OP_PUT_EXIT;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) begin
          msel_next  = M_QC;
          ret_next   = S_PLO;
          state_next = S_MLO;
        end
      end
      S_MLO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_MSUM;
      end
      S_MSUM: begin
        cmd.op     = OP_MUL_SUM;
        state_next = ret;
      end
      S_PLO: begin
        cmd.op     = OP_PUT_LO;
        msel_next  = M_QR;
        ret_next   = S_PQ;
        state_next = S_MLO;
      end
      S_PQ: begin
        cmd.op     = OP_SET_R;
        state_next = S_PCARRY;
      end
      S_PCARRY: if (stat.slot_free) begin
        cmd.op     = OP_CARRY_PUT;
        state_next = stat.put_small ? S_PPUSH : S_PDONE;
      end
      S_PPUSH: if (stat.slot_free) begin
        cmd.op = OP_PUSH;
        if (stat.k_is2) state_next = S_PDONE;
      end
      S_PDONE: begin
        cmd.op     = OP_PUT_DONE;
        state_next = S_FLUSH;
      end
      S_SENTER: begin
        cmd.op     = OP_SYM_ENTER;
        msel_next  = M_RC;
        ret_next   = S_SADD;
        state_next = S_MLO;
      end
      S_SADD: begin
        cmd.op     = OP_SYM_ADD;
        msel_next  = M_RR;
        ret_next   = S_SR;
        state_next = S_MLO;
      end
      S_SR: begin
        cmd.op     = OP_SET_R;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (!stat.sym_small) begin
          state_next = S_SDONE;
        end else if (stat.slot_free) begin
          cmd.op     = OP_CARRY_LAR;
          state_next = S_SSHF;
        end
      end
      S_SSHF: begin
        cmd.op     = OP_SHF_LOW;
        state_next = S_SPUSH;
      end
      S_SPUSH: if (stat.slot_free) begin
        cmd.op = OP_PUSH;
        if (stat.k_is2) state_next = S_SDONE;
      end
      S_SDONE: begin
        cmd.op     = OP_SYM_DONE;
        state_next = S_FLUSH;
      end
      S_FENTER: begin
        cmd.op     = OP_SYM_ENTER;
        state_next = S_FCHK;
      end
      S_FCHK: if (stat.slot_free) begin
        cmd.op     = OP_CARRY_LAR;
        state_next = S_FT;
      end
      S_FT: begin
        cmd.op     = OP_FIN_T;
        state_next = S_FHI;
      end
      S_FHI: begin
        cmd.op     = OP_FIN_HI;
        state_next = S_FD;
      end
      S_FD: begin
        cmd.op     = OP_FIN_D;
        state_next = S_FSEL;
      end
      S_FSEL: begin
        if (stat.hi_gt) begin
          state_next = S_FLOOP;
        end else if (stat.slot_free) begin
          cmd.op     = OP_CARRY;
          state_next = S_FEMIT;
        end
      end
      S_FLOOP: if (stat.slot_free) begin
        cmd.op = OP_PUSH;
        // the push after the last matching byte is the closing one
        if (!stat.fin_more) state_next = S_FEMIT;
      end
      S_FEMIT: if (stat.slot_free) begin
        cmd.op     = OP_FIN_EMIT;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!stat.stg_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.op     = OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `RCBO_ASSERT_IMP(a_idle_drained, in_ready, !stat.stg_valid,
                   "new transaction taken while a result is still staged")
  `RCBO_ASSERT(a_mul_ret, state != S_MSUM ||
               ret == S_PLO || ret == S_PQ || ret == S_SADD || ret == S_SR,
               "multiply sequence returns to an unexpected step")

endmodule

// File: sv/range_coder_byte_output.sv
// ----------------------------------------------------------------------------
// range_coder_byte_output
// Range coder core with 64-bit low, cache byte carry resolution and run output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One transaction is taken at a time; in_ready is high only while the
// sequencer is idle. A symbol does two multiplies, each done as two 32x17
// halves plus a sum, and when it renormalizes a carry check, a shift and
// three byte pushes. A general put first runs a 64-step restoring divider,
// one quotient bit per cycle, then two multiplies; it adds a carry check
// and an exit from symbol mode when it leaves symbol mode, and three byte
// pushes on renormalization. Finish pushes 1 to 8 tail bytes, or applies
// only a carry when the interval wraps. Any byte push or carry that may
// produce a result waits while both the staging register and the output
// register are full, so a stalled consumer stretches a transaction.
// Results leave through an output register: a finished result may still
// wait there while the next transaction is accepted. Each result is a lead
// byte and a fill run; last marks the final result of its transaction.
// Command 3 is accepted and produces nothing.

module range_coder_byte_output #(
  parameter int PROB_BITS    = rcbo_pkg::PROB_BITS_DEF,
  parameter int PENDING_BITS = rcbo_pkg::PENDING_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [rcbo_pkg::FIELD_W-1:0] scale,
  input  logic [rcbo_pkg::FIELD_W-1:0] cum_low,
  input  logic [rcbo_pkg::FIELD_W-1:0] cum_range,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic [31:0]                  fill_count,
  output logic [7:0]                   fill_value,
  output logic                         last
);
  import rcbo_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer
  rcbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // coder state, arithmetic and result registers
  rcbo_datapath #(
    .PROB_BITS    (PROB_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .scale      (scale),
    .cum_low    (cum_low),
    .cum_range  (cum_range),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .fill_count (fill_count),
    .fill_value (fill_value),
    .last       (last)
  );

endmodule
